// ----- design/ots_pkg.sv -----
// Operator token scanner: shared types, character codes and lookup functions.
// Used by every module of the scanner. No dependencies.
package ots_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChLt      = 8'h3C;
  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChBar     = 8'h7C;
  localparam logic [7:0] ChRBrace  = 8'h7D;

  typedef enum logic [4:0] {
    KindMinus   = 5'd0,
    KindStar    = 5'd1,
    KindPlus    = 5'd2,
    KindSlash   = 5'd3,
    KindLt      = 5'd4,
    KindGt      = 5'd5,
    KindLe      = 5'd6,
    KindGe      = 5'd7,
    KindEqEq    = 5'd8,
    KindNe      = 5'd9,
    KindBang    = 5'd10,
    KindAmp     = 5'd11,
    KindBar     = 5'd12,
    KindAndAnd  = 5'd13,
    KindOrOr    = 5'd14,
    KindLParen  = 5'd15,
    KindRParen  = 5'd16,
    KindLBrace  = 5'd17,
    KindRBrace  = 5'd18,
    KindSemi    = 5'd19,
    KindLiteral = 5'd20,
    KindUnterm  = 5'd21
  } kind_e;

  typedef enum logic [2:0] {
    PendNone = 3'd0,
    PendLt   = 3'd1,
    PendGt   = 3'd2,
    PendEq   = 3'd3,
    PendBang = 3'd4,
    PendAmp  = 3'd5,
    PendBar  = 3'd6
  } pend_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] row;
    logic [11:0] col;
    logic [7:0]  len;
  } tok_t;

  // One queue entry: all tokens caused by one input item.
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } run_t;

  function automatic pend_e pend_code(input logic [7:0] b);
    pend_e p;
    case (b)
      ChLt:    p = PendLt;
      ChGt:    p = PendGt;
      ChEq:    p = PendEq;
      ChBang:  p = PendBang;
      ChAmp:   p = PendAmp;
      ChBar:   p = PendBar;
      default: p = PendNone;
    endcase
    return p;
  endfunction

  function automatic logic simple_hit(input logic [7:0] b);
    logic h;
    case (b)
      ChMinus, ChStar, ChPlus, ChSlash, ChLParen, ChRParen,
      ChLBrace, ChRBrace, ChSemi: h = 1'b1;
      default: h = 1'b0;
    endcase
    return h;
  endfunction

  function automatic kind_e simple_kind(input logic [7:0] b);
    kind_e k;
    case (b)
      ChMinus:  k = KindMinus;
      ChStar:   k = KindStar;
      ChPlus:   k = KindPlus;
      ChSlash:  k = KindSlash;
      ChLParen: k = KindLParen;
      ChRParen: k = KindRParen;
      ChLBrace: k = KindLBrace;
      ChRBrace: k = KindRBrace;
      default:  k = KindSemi;
    endcase
    return k;
  endfunction

  // '=' alone and the idle code have no single form.
  function automatic logic single_hit(input pend_e p);
    logic h;
    case (p)
      PendLt, PendGt, PendBang, PendAmp, PendBar: h = 1'b1;
      default: h = 1'b0;
    endcase
    return h;
  endfunction

  function automatic kind_e single_kind(input pend_e p);
    kind_e k;
    case (p)
      PendLt:   k = KindLt;
      PendGt:   k = KindGt;
      PendBang: k = KindBang;
      PendAmp:  k = KindAmp;
      default:  k = KindBar;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] pair_byte(input pend_e p);
    logic [7:0] c;
    case (p)
      PendAmp: c = ChAmp;
      PendBar: c = ChBar;
      default: c = ChEq;
    endcase
    return c;
  endfunction

  function automatic kind_e pair_kind(input pend_e p);
    kind_e k;
    case (p)
      PendLt:   k = KindLe;
      PendGt:   k = KindGe;
      PendEq:   k = KindEqEq;
      PendBang: k = KindNe;
      PendAmp:  k = KindAndAnd;
      default:  k = KindOrOr;
    endcase
    return k;
  endfunction

endpackage

// ----- design/ots_front.sv -----
// Scanner front end: takes one byte per cycle while take_i is high, tracks
// position, lookahead and literal mode, and writes the tokens of each byte as one run. Uses ots_pkg.
module ots_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       text_byte_i,
  input  logic             end_of_text_i,
  output logic             push_o,
  output ots_pkg::run_t    run_o
);

  ots_pkg::pend_e pend_q, pend_d;
  logic           in_lit_q, in_lit_d;
  logic [15:0]    line_q, line_d;
  logic [11:0]    col_q, col_d;
  logic [11:0]    scol_q, scol_d;
  logic [15:0]    srow_q, srow_d;
  logic [7:0]     cnt_q, cnt_d;

  logic           have_a, have_b;
  ots_pkg::tok_t  tok_a, tok_b;

  always_comb begin
    logic pend_live;
    logic fresh;
    pend_d    = pend_q;
    in_lit_d  = in_lit_q;
    line_d    = line_q;
    col_d     = col_q;
    scol_d    = scol_q;
    srow_d    = srow_q;
    cnt_d     = cnt_q;
    have_a    = 1'b0;
    have_b    = 1'b0;
    tok_a     = '{kind: ots_pkg::KindMinus, row: srow_q, col: scol_q, len: 8'd1};
    tok_b     = '{kind: ots_pkg::KindMinus, row: line_q, col: col_q, len: 8'd1};
    pend_live = ots_pkg::single_hit(pend_q) || (pend_q == ots_pkg::PendEq);
    fresh     = 1'b1;

    if (end_of_text_i) begin
      have_a     = ots_pkg::single_hit(pend_q);
      tok_a.kind = ots_pkg::single_kind(pend_q);
      have_b     = in_lit_q;
      tok_b      = '{kind: ots_pkg::KindUnterm, row: srow_q, col: scol_q, len: cnt_q};
      pend_d     = ots_pkg::PendNone;
      in_lit_d   = 1'b0;
      line_d     = 16'd1;
      col_d      = '0;
      scol_d     = '0;
      srow_d     = 16'd1;
      cnt_d      = '0;
    end else begin
      if (col_q != '1) col_d = col_q + 12'd1;
      if (text_byte_i == ots_pkg::ChNewline) begin
        if (line_q != '1) line_d = line_q + 16'd1;
        col_d = '0;
      end

      if (in_lit_q) begin
        if (cnt_q != '1) cnt_d = cnt_q + 8'd1;
        if (text_byte_i == ots_pkg::ChQuote) begin
          have_b   = 1'b1;
          tok_b    = '{kind: ots_pkg::KindLiteral, row: srow_q, col: scol_q, len: cnt_d};
          in_lit_d = 1'b0;
          cnt_d    = '0;
        end
      end else begin
        pend_d = ots_pkg::PendNone;
        if (pend_live) begin
          if (text_byte_i == ots_pkg::pair_byte(pend_q)) begin
            have_a     = 1'b1;
            tok_a.kind = ots_pkg::pair_kind(pend_q);
            tok_a.len  = 8'd2;
            fresh      = 1'b0;
          end else begin
            have_a     = ots_pkg::single_hit(pend_q);
            tok_a.kind = ots_pkg::single_kind(pend_q);
          end
        end
        if (fresh) begin
          if (ots_pkg::simple_hit(text_byte_i)) begin
            have_b = 1'b1;
            tok_b  = '{kind: ots_pkg::simple_kind(text_byte_i), row: line_d, col: col_d,
                       len: 8'd1};
          end else if (ots_pkg::pend_code(text_byte_i) != ots_pkg::PendNone) begin
            pend_d = ots_pkg::pend_code(text_byte_i);
            srow_d = line_d;
            scol_d = col_d;
          end else if (text_byte_i == ots_pkg::ChQuote) begin
            in_lit_d = 1'b1;
            cnt_d    = 8'd1;
            srow_d   = line_d;
            scol_d   = col_d;
          end
        end
      end
    end
  end

  assign push_o   = take_i && (have_a || have_b);
  assign run_o.two  = have_a && have_b;
  assign run_o.tok0 = have_a ? tok_a : tok_b;
  assign run_o.tok1 = tok_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= ots_pkg::PendNone;
      in_lit_q <= 1'b0;
      line_q   <= 16'd1;
      col_q    <= '0;
      scol_q   <= '0;
      srow_q   <= 16'd1;
      cnt_q    <= '0;
    end else if (take_i) begin
      pend_q   <= pend_d;
      in_lit_q <= in_lit_d;
      line_q   <= line_d;
      col_q    <= col_d;
      scol_q   <= scol_d;
      srow_q   <= srow_d;
      cnt_q    <= cnt_d;
    end
  end

  a_lit_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_lit_q |-> pend_q == ots_pkg::PendNone)
    else $error("operator pending inside literal");

  a_lit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_lit_q |-> cnt_q != '0)
    else $error("open literal with zero length");

endmodule

// ----- design/ots_queue.sv -----
// Short run queue between scanner front and back ends, register storage.
// Uses ots_pkg for the entry type.
module ots_queue #(
  parameter int unsigned Depth = ots_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ots_pkg::run_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ots_pkg::run_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ots_pkg::run_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with pointers apart");

endmodule

// ----- design/ots_back.sv -----
// Scanner back end: splits each queued run into tokens, one per cycle while
// the receiver is ready, into the output register. Uses ots_pkg.
module ots_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  ots_pkg::run_t q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ots_pkg::tok_t tok_o,
  output logic          last_o
);

  logic          valid_q, valid_d;
  logic          sel_q, sel_d;
  logic          last_q;
  ots_pkg::tok_t tok_q;
  logic          load, last_sel;

  assign load     = !valid_q || out_ready_i;
  assign last_sel = !q_data_i.two || sel_q;
  assign q_pop_o  = load && q_valid_i && last_sel;
  assign valid_d  = load ? q_valid_i : valid_q;
  assign sel_d    = (load && q_valid_i) ? !last_sel : sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      tok_q  <= sel_q ? q_data_i.tok1 : q_data_i.tok0;
      last_q <= last_sel;
    end
  end

  assign out_valid_o = valid_q;
  assign tok_o       = tok_q;
  assign last_o      = last_q;

  a_sel_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (q_valid_i && q_data_i.two))
    else $error("second token selected without a two-token run");

  a_sel_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sel_q) |-> (valid_q && !last_q))
    else $error("second token pending without first shown");

endmodule

// ----- design/operator_token_scanner.sv -----
// Operator token scanner, top level: front end, run queue and back end.
// Uses ots_pkg, ots_front, ots_queue, ots_back.
//
// Input channel: one source byte per item (text_byte_i), or an end marker
// (end_of_text_i) that flushes a pending operator or open literal and
// returns position and mode to their start values.
// Output channel: one token per item, with kind, row, column and length;
// last_of_run_o marks the final token caused by one input item.
// Each input item causes zero, one or two tokens.
// Throughput: one input item per cycle while the run queue has room; the
// output side emits one token per cycle while the receiver is ready. Each
// run is registered in the queue, then each token in the output register.
// The run queue (QueueDepth entries) lets the input keep flowing while the
// receiver stalls; when it fills, in_ready_o drops until tokens drain.
// Reset clears position to row 1, column 0, the queue and out_valid_o. The
// user must have no item accepted during reset; the block does not enforce it.
module operator_token_scanner #(
  parameter int unsigned QueueDepth = ots_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] token_row_o,
  output logic [11:0] token_column_o,
  output logic [7:0]  token_length_o,
  output logic        last_of_run_o
);

  logic          q_full, q_push, q_valid, q_pop, take;
  ots_pkg::run_t run_in, run_out;
  ots_pkg::tok_t tok;

  assign in_ready_o = !q_full;
  assign take       = in_valid_i && in_ready_o;

  ots_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (q_push),
    .run_o         (run_in)
  );

  ots_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (run_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (run_out)
  );

  ots_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (run_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tok_o       (tok),
    .last_o      (last_of_run_o)
  );

  assign token_kind_o   = tok.kind;
  assign token_row_o    = tok.row;
  assign token_column_o = tok.col;
  assign token_length_o = tok.len;

endmodule

// ----- tb/ots_tracker_pkg.sv -----
`timescale 1ns / 100ps
// Token tracker for the operator token scanner testbench: predicts the tokens
// caused by each accepted item and checks each token taken from the block.
// Depends on ots_pkg for the character codes and the kind and pending enums.
package ots_tracker_pkg;
  import ots_pkg::*;

  class token_tracker;
    typedef struct {
      kind_e       kind;
      logic [15:0] row;
      logic [11:0] col;
      logic [7:0]  len;
      logic        last;
    } token_t;

    token_t      due_tokens[$];
    int unsigned mismatches;

    pend_e       held_op;
    bit          in_quote;
    logic [15:0] line_no;
    logic [11:0] col_no;
    logic [15:0] tok_row;
    logic [11:0] tok_col;
    logic [7:0]  quote_len;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      held_op   = PendNone;
      in_quote  = 1'b0;
      line_no   = 16'd1;
      col_no    = 12'd0;
      tok_row   = 16'd1;
      tok_col   = 12'd0;
      quote_len = 8'd0;
    endfunction

    function token_t mk(kind_e kind, logic [15:0] row, logic [11:0] col, logic [7:0] len);
      token_t t;
      t.kind = kind;
      t.row  = row;
      t.col  = col;
      t.len  = len;
      t.last = 1'b0;
      return t;
    endfunction

    function kind_e lone_kind(pend_e p);
      case (p)
        PendLt:   return KindLt;
        PendGt:   return KindGt;
        PendBang: return KindBang;
        PendAmp:  return KindAmp;
        default:  return KindBar;
      endcase
    endfunction

    function void open_op(pend_e p);
      held_op = p;
      tok_row = line_no;
      tok_col = col_no;
    endfunction

    // Notes one accepted item and queues the tokens it causes.
    function void take_byte(logic [7:0] b, logic eot);
      token_t     run[$];
      pend_e      code;
      logic [7:0] closer;
      kind_e      pk;
      bit         fresh;
      if (eot) begin
        if (held_op != PendNone && held_op != PendEq) begin
          run.push_back(mk(lone_kind(held_op), tok_row, tok_col, 8'd1));
        end
        if (in_quote) begin
          run.push_back(mk(KindUnterm, tok_row, tok_col, quote_len));
        end
        clear();
      end else begin
        if (col_no != 12'hFFF) col_no++;
        if (b == ChNewline) begin
          if (line_no != 16'hFFFF) line_no++;
          col_no = 12'd0;
        end
        if (in_quote) begin
          if (quote_len != 8'hFF) quote_len++;
          if (b == ChQuote) begin
            run.push_back(mk(KindLiteral, tok_row, tok_col, quote_len));
            in_quote  = 1'b0;
            quote_len = 8'd0;
          end
        end else begin
          fresh   = 1'b1;
          code    = held_op;
          held_op = PendNone;
          if (code != PendNone) begin
            closer = (code == PendAmp) ? ChAmp : (code == PendBar) ? ChBar : ChEq;
            case (code)
              PendLt:   pk = KindLe;
              PendGt:   pk = KindGe;
              PendEq:   pk = KindEqEq;
              PendBang: pk = KindNe;
              PendAmp:  pk = KindAndAnd;
              default:  pk = KindOrOr;
            endcase
            if (b == closer) begin
              run.push_back(mk(pk, tok_row, tok_col, 8'd2));
              fresh = 1'b0;
            end else if (code != PendEq) begin
              run.push_back(mk(lone_kind(code), tok_row, tok_col, 8'd1));
            end
          end
          if (fresh) begin
            case (b)
              ChMinus:  run.push_back(mk(KindMinus, line_no, col_no, 8'd1));
              ChStar:   run.push_back(mk(KindStar, line_no, col_no, 8'd1));
              ChPlus:   run.push_back(mk(KindPlus, line_no, col_no, 8'd1));
              ChSlash:  run.push_back(mk(KindSlash, line_no, col_no, 8'd1));
              ChLParen: run.push_back(mk(KindLParen, line_no, col_no, 8'd1));
              ChRParen: run.push_back(mk(KindRParen, line_no, col_no, 8'd1));
              ChLBrace: run.push_back(mk(KindLBrace, line_no, col_no, 8'd1));
              ChRBrace: run.push_back(mk(KindRBrace, line_no, col_no, 8'd1));
              ChSemi:   run.push_back(mk(KindSemi, line_no, col_no, 8'd1));
              ChLt:     open_op(PendLt);
              ChGt:     open_op(PendGt);
              ChEq:     open_op(PendEq);
              ChBang:   open_op(PendBang);
              ChAmp:    open_op(PendAmp);
              ChBar:    open_op(PendBar);
              ChQuote: begin
                in_quote  = 1'b1;
                quote_len = 8'd1;
                tok_row   = line_no;
                tok_col   = col_no;
              end
              default: ;
            endcase
          end
        end
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) due_tokens.push_back(run[i]);
    endfunction

    // Checks one token taken from the block against the oldest expectation.
    function void match_token(logic [4:0] kind, logic [15:0] row, logic [11:0] col,
                              logic [7:0] len, logic last);
      token_t want;
      if (due_tokens.size() == 0) begin
        $error("unexpected token: kind %0d row %0d column %0d", kind, row, col);
        mismatches++;
        return;
      end
      want = due_tokens.pop_front();
      if (kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, kind);
        mismatches++;
      end
      if (row !== want.row) begin
        $error("token_row: expected %0d, got %0d", want.row, row);
        mismatches++;
      end
      if (col !== want.col) begin
        $error("token_column: expected %0d, got %0d", want.col, col);
        mismatches++;
      end
      if (len !== want.len) begin
        $error("token_length: expected %0d, got %0d", want.len, len);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_operator_token_scanner.sv -----
`timescale 1ns / 100ps
// Testbench for operator_token_scanner: directed, saturation and random text
// with random idling on both sides, checked against the token tracker.
// Depends on ots_pkg and ots_tracker_pkg.
module tb_operator_token_scanner;
  import ots_pkg::*;
  import ots_tracker_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomItems = 650;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  text_byte;
  logic        end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  token_kind;
  logic [15:0] token_row;
  logic [11:0] token_column;
  logic [7:0]  token_length;
  logic        last_of_run;

  token_tracker tracker;
  bit           steady;
  int unsigned  quiet_cycles;

  operator_token_scanner dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .text_byte_i    (text_byte),
    .end_of_text_i  (end_of_text),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_o   (token_kind),
    .token_row_o    (token_row),
    .token_column_o (token_column),
    .token_length_o (token_length),
    .last_of_run_o  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_item(input logic [7:0] b, input logic eot);
    if (!steady && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(b, eot);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_byte();
    string       ops;
    string       plain;
    int unsigned r;
    ops   = "-*+/(){};<>=!&|";
    plain = "ab1_x Z\t";
    r     = $urandom_range(99);
    if (r < 34) return ops[$urandom_range(ops.len() - 1)];
    if (r < 42) return ChQuote;
    if (r < 50) return ChNewline;
    if (r < 75) return plain[$urandom_range(plain.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  // Token sink: random back-pressure, every taken token is checked.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        tracker.match_token(token_kind, token_row, token_column, token_length, last_of_run);
      end
      out_ready <= steady || ($urandom_range(99) >= 9);
    end
  end

  initial begin
    quiet_cycles = 0;
    wait (rst_n === 1'b1);
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    tracker     = new();
    steady      = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    text_byte   = 8'd0;
    end_of_text = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every operator, lookahead pairs and breaks, lone '=', literal across a line
    send_text("-*+/(){};<=>a==!(=b!=&|||\"\n");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_text("\"&");
    send_item(8'($urandom_range(255)), 1'b1);
    send_text("\"x");
    send_item(8'($urandom_range(255)), 1'b1);
    send_item(8'($urandom_range(255)), 1'b1);
    send_item(ChEq, 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);

    // saturation of literal length
    steady = 1'b1;
    send_item(ChPlus, 1'b0);
    send_item(ChQuote, 1'b0);
    repeat (260) send_item("x", 1'b0);
    send_item(ChQuote, 1'b0);
    send_text("+<");
    send_item(8'($urandom_range(255)), 1'b1);

    for (int i = 0; i < RandomItems; i++) begin
      steady = (i < 200);
      if ($urandom_range(99) < 2) send_item(8'($urandom_range(255)), 1'b1);
      else send_item(pick_byte(), 1'b0);
    end
    steady = 1'b0;
    send_item(8'($urandom_range(255)), 1'b1);
    in_valid <= 1'b0;

    while (tracker.due_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/ots_pkg.sv
design/ots_front.sv
design/ots_queue.sv
design/ots_back.sv
design/operator_token_scanner.sv
tb/ots_tracker_pkg.sv
tb/tb_operator_token_scanner.sv
